// ----- rtl/ccir_pkg.sv -----
package ccir_pkg;

    // Field and register widths.
    localparam int VEL_W      = 32;
    localparam int LANES      = 4;
    localparam int TDATA_W    = LANES * VEL_W;
    localparam int TUSER_W    = 2;
    localparam int ENT_W      = 16;
    localparam int ROW_W      = 48;
    localparam int ROWS       = 3;
    localparam int MU_W       = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Datapath widths.
    localparam int PROD_W     = ENT_W + VEL_W;      // entry times velocity
    localparam int P_W        = PROD_W + 1;         // sum of two such products
    localparam int MAG_W      = PROD_W;             // magnitude of that sum
    localparam int RAD_W      = 2 * VEL_W;          // squared speed
    localparam int ROOT_W     = VEL_W;              // speed
    localparam int CORR_NUM_W = MAG_W + MU_W;       // friction numerator
    localparam int CORR_W     = 34;                 // friction correction, Q.24
    localparam int K_W        = 36;                 // corrected column entry, Q.24
    localparam int NUM_W      = 57;                 // signed output numerator
    localparam int NMAG_W     = NUM_W - 1;          // its magnitude
    localparam int DEN_W      = K_W;                // output divisor magnitude
    localparam int QUO_W      = VEL_W;              // output quotient magnitude

    // Fixed-point alignment shifts.
    localparam int FRAC_SHIFT  = 12;  // Q4.12 entry to Q.24
    localparam int SH_COMP_K   = 16;
    localparam int SH_COMP_ONE = 40;
    localparam int SH_COMP_T   = 24;
    localparam int SH_REST_K   = 8;
    localparam int SH_REST_ONE = 32;

    // Matrix columns within a row.
    localparam int COL_X = 0;
    localparam int COL_Y = 1;
    localparam int COL_Z = 2;

    localparam logic [VEL_W-1:0] SAT_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0] SAT_MIN = {1'b1, {(VEL_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRICTION = 3'd0,
        CFG_ROW_X    = 3'd1,
        CFG_ROW_Y    = 3'd2,
        CFG_ROW_Z    = 3'd3,
        CFG_PHASE    = 3'd4
    } cfg_idx_t;

    typedef logic signed [ENT_W-1:0] entry_t;

    // Sideband that travels with the output divider.
    typedef struct packed {
        logic [LANES-1:0] sneg;  // quotient is negative
        logic [LANES-1:0] nz;    // numerator is nonzero
        logic [LANES-1:0] ov;    // quotient magnitude at least 2^32
        logic             err;   // nonpositive normal velocity
        logic             dz;    // divisor is zero
    } quo_side_t;

    function automatic entry_t row_entry(input logic [ROW_W-1:0] row, input int col);
        return row[col*ENT_W +: ENT_W];
    endfunction

    function automatic logic signed [PROD_W-1:0] mul_ent(input entry_t a,
                                                         input logic signed [VEL_W-1:0] b);
        return PROD_W'(a) * PROD_W'(b);
    endfunction

    function automatic logic [RAD_W-1:0] square(input logic signed [VEL_W-1:0] v);
        logic signed [RAD_W-1:0] p;
        p = RAD_W'(v) * RAD_W'(v);
        return p;
    endfunction

endpackage

// ----- rtl/collision_impulse_ode_rhs.sv -----
// Frictional impact ODE right-hand side. Each input item is one state sample
// (transverse velocity x/y, independent variable, fourth state element, all
// signed Q16.16); each result item carries the four saturated derivatives and
// the error and overflow flags. The block is a 105-stage pipeline that takes
// one item per clock while the output is not stalled. The depth is set by the
// bit-per-stage square root (32 stages), the friction divider (34 stages) and
// the output divider (32 stages). A stall on the output holds the whole
// pipeline in place. Registers are written through the configuration channel,
// which is always ready, and must only be changed while no item is in flight.
module collision_impulse_ode_rhs
    import ccir_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tangent_vel_x, tangent_vel_y, indep_var, fourth_component
    input  logic [TDATA_W-1:0]    s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // rate_vel_x, rate_vel_y, rate_impulse, rate_fourth
    output logic [TDATA_W-1:0]    m_tdata,
    // nonpositive_error, overflow_flag
    output logic [TUSER_W-1:0]    m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SQ_SIDE_W = ROWS * P_W + 2 * VEL_W;
    localparam int C_SIDE_W  = ROWS + 1 + 2 * VEL_W;
    localparam int OV_W      = DEN_W + QUO_W;

    logic en;

    // Configuration registers.
    logic [MU_W-1:0]  mu_reg;
    logic [ROW_W-1:0] row_reg [ROWS];
    logic             phase_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg     <= '0;
            row_reg[0] <= '0;
            row_reg[1] <= '0;
            row_reg[2] <= '0;
            phase_reg  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FRICTION: mu_reg     <= cfg_data[MU_W-1:0];
                CFG_ROW_X:    row_reg[0] <= cfg_data;
                CFG_ROW_Y:    row_reg[1] <= cfg_data;
                CFG_ROW_Z:    row_reg[2] <= cfg_data;
                CFG_PHASE:    phase_reg  <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // The whole pipeline advances unless the output holds an untaken item.
    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    logic signed [VEL_W-1:0] in_ux;
    logic signed [VEL_W-1:0] in_uy;
    logic signed [VEL_W-1:0] in_t;
    logic signed [VEL_W-1:0] in_w;

    assign in_ux = s_tdata[0*VEL_W +: VEL_W];
    assign in_uy = s_tdata[1*VEL_W +: VEL_W];
    assign in_t  = s_tdata[2*VEL_W +: VEL_W];
    assign in_w  = s_tdata[3*VEL_W +: VEL_W];

    // Stage A: squares of the speed components and row-times-velocity products.
    logic                     a_vld_reg;
    logic [RAD_W-1:0]         a_sqx_reg;
    logic [RAD_W-1:0]         a_sqy_reg;
    logic signed [PROD_W-1:0] a_pa_reg [ROWS];
    logic signed [PROD_W-1:0] a_pb_reg [ROWS];
    logic signed [VEL_W-1:0]  a_t_reg;
    logic signed [VEL_W-1:0]  a_w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (en)
            a_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_sqx_reg <= square(in_ux);
            a_sqy_reg <= square(in_uy);
            for (int i = 0; i < ROWS; i++)
            begin
                a_pa_reg[i] <= mul_ent(row_entry(row_reg[i], COL_X), in_ux);
                a_pb_reg[i] <= mul_ent(row_entry(row_reg[i], COL_Y), in_uy);
            end
            a_t_reg <= in_t;
            a_w_reg <= in_w;
        end
    end

    // Stage B: squared speed and the sliding-direction projections.
    logic                    b_vld_reg;
    logic [RAD_W-1:0]        b_sq_reg;
    logic signed [P_W-1:0]   b_p_reg [ROWS];
    logic signed [VEL_W-1:0] b_t_reg;
    logic signed [VEL_W-1:0] b_w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (en)
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_sq_reg <= a_sqx_reg + a_sqy_reg;
            for (int i = 0; i < ROWS; i++)
                b_p_reg[i] <= P_W'(a_pa_reg[i]) + P_W'(a_pb_reg[i]);
            b_t_reg <= a_t_reg;
            b_w_reg <= a_w_reg;
        end
    end

    // Transverse speed.
    logic [SQ_SIDE_W-1:0] sq_side_in;
    logic [SQ_SIDE_W-1:0] r_side;
    logic                 r_vld;
    logic [ROOT_W-1:0]    r_root;

    assign sq_side_in = {b_p_reg[2], b_p_reg[1], b_p_reg[0], b_t_reg, b_w_reg};

    ccir_sqrt #(
        .RAD_W  (RAD_W),
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_vld_reg),
        .in_rad    (b_sq_reg),
        .in_side   (sq_side_in),
        .out_valid (r_vld),
        .out_root  (r_root),
        .out_side  (r_side)
    );

    // Stage M: friction numerators mu * |p|.
    logic                                m_vld_reg;
    logic [ROWS-1:0][CORR_NUM_W-1:0]     m_num_reg;
    logic [ROWS-1:0]                     m_neg_reg;
    logic [ROOT_W-1:0]                   m_u_reg;
    logic                                m_unz_reg;
    logic signed [VEL_W-1:0]             m_t_reg;
    logic signed [VEL_W-1:0]             m_w_reg;
    logic [ROWS-1:0][CORR_NUM_W-1:0]     m_num_next;
    logic [ROWS-1:0]                     m_neg_next;

    always_comb
    begin
        logic signed [P_W-1:0] p;
        logic signed [P_W-1:0] p_abs;
        for (int i = 0; i < ROWS; i++)
        begin
            p             = r_side[2*VEL_W + i*P_W +: P_W];
            p_abs         = p[P_W-1] ? -p : p;
            m_neg_next[i] = p[P_W-1];
            m_num_next[i] = CORR_NUM_W'(p_abs[MAG_W-1:0]) * CORR_NUM_W'(mu_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else if (en)
            m_vld_reg <= r_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_num_reg <= m_num_next;
            m_neg_reg <= m_neg_next;
            m_u_reg   <= r_root;
            m_unz_reg <= (r_root != '0);
            m_t_reg   <= r_side[VEL_W +: VEL_W];
            m_w_reg   <= r_side[0 +: VEL_W];
        end
    end

    // Friction corrections mu * |p| / u for all three rows.
    logic [C_SIDE_W-1:0]          c_side_in;
    logic [C_SIDE_W-1:0]          c_side;
    logic                         c_vld;
    logic [ROWS-1:0][CORR_W-1:0]  c_corr;

    assign c_side_in = {m_neg_reg, m_unz_reg, m_t_reg, m_w_reg};

    ccir_div #(
        .LANES  (ROWS),
        .NUM_W  (CORR_NUM_W),
        .DEN_W  (ROOT_W),
        .Q_W    (CORR_W),
        .SIDE_W (C_SIDE_W)
    ) u_corr_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_vld_reg),
        .in_num    (m_num_reg),
        .in_den    (m_u_reg),
        .in_side   (c_side_in),
        .out_valid (c_vld),
        .out_quo   (c_corr),
        .out_side  (c_side)
    );

    // Stage K: corrected normal column in Q.24.
    logic                    k_vld_reg;
    logic signed [K_W-1:0]   k_k_reg [ROWS];
    logic signed [VEL_W-1:0] k_t_reg;
    logic signed [VEL_W-1:0] k_w_reg;
    logic signed [K_W-1:0]   k_k_next [ROWS];

    always_comb
    begin
        logic signed [K_W-1:0] base;
        logic signed [K_W-1:0] corr;
        logic [ROWS-1:0]       neg;
        logic                  unz;
        neg = c_side[C_SIDE_W-1 -: ROWS];
        unz = c_side[2*VEL_W];
        for (int i = 0; i < ROWS; i++)
        begin
            base = K_W'(row_entry(row_reg[i], COL_Z)) <<< FRAC_SHIFT;
            corr = K_W'(c_corr[i]);
            if (!unz)
                k_k_next[i] = base;
            else if (neg[i])
                k_k_next[i] = base + corr;
            else
                k_k_next[i] = base - corr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_vld_reg <= 1'b0;
        else if (en)
            k_vld_reg <= c_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < ROWS; i++)
                k_k_reg[i] <= k_k_next[i];
            k_t_reg <= c_side[VEL_W +: VEL_W];
            k_w_reg <= c_side[0 +: VEL_W];
        end
    end

    // Stage N: numerators and divisor for the phase, as sign and magnitude.
    logic                          n_vld_reg;
    logic [LANES-1:0][NMAG_W-1:0]  n_mag_reg;
    logic [DEN_W-1:0]              n_dmag_reg;
    quo_side_t                     n_side_reg;
    logic [LANES-1:0][NMAG_W-1:0]  n_mag_next;
    logic [DEN_W-1:0]              n_dmag_next;
    quo_side_t                     n_side_next;

    always_comb
    begin
        logic signed [NUM_W-1:0] num [LANES];
        logic signed [K_W-1:0]   den;
        logic signed [K_W-1:0]   den_abs;
        logic signed [NUM_W-1:0] num_abs;
        logic                    den_neg;
        if (phase_reg)
        begin
            num[0] = NUM_W'(k_k_reg[0]) <<< SH_COMP_K;
            num[1] = NUM_W'(k_k_reg[1]) <<< SH_COMP_K;
            num[2] = NUM_W'(1) << SH_COMP_ONE;
            num[3] = NUM_W'(k_t_reg) <<< SH_COMP_T;
            den    = k_k_reg[2];
        end
        else
        begin
            num[0] = NUM_W'(k_k_reg[0]) <<< SH_REST_K;
            num[1] = NUM_W'(k_k_reg[1]) <<< SH_REST_K;
            num[2] = NUM_W'(1) << SH_REST_ONE;
            num[3] = NUM_W'(k_k_reg[2]) <<< SH_REST_K;
            den    = K_W'(k_w_reg);
        end
        den_neg     = den[K_W-1];
        den_abs     = den_neg ? -den : den;
        n_dmag_next = den_abs;
        n_side_next = '0;
        for (int l = 0; l < LANES; l++)
        begin
            num_abs             = num[l][NUM_W-1] ? -num[l] : num[l];
            n_mag_next[l]       = num_abs[NMAG_W-1:0];
            n_side_next.nz[l]   = (num[l] != '0);
            n_side_next.sneg[l] = num[l][NUM_W-1] ^ den_neg;
        end
        n_side_next.err = !phase_reg && (k_w_reg[VEL_W-1] || k_w_reg == '0);
        n_side_next.dz  = (den == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_vld_reg <= 1'b0;
        else if (en)
            n_vld_reg <= k_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_mag_reg  <= n_mag_next;
            n_dmag_reg <= n_dmag_next;
            n_side_reg <= n_side_next;
        end
    end

    // Stage P: flag quotients of 2^32 or more, and clear them before dividing.
    logic                          p_vld_reg;
    logic [LANES-1:0][NMAG_W-1:0]  p_mag_reg;
    logic [DEN_W-1:0]              p_dmag_reg;
    quo_side_t                     p_side_reg;
    logic [LANES-1:0][NMAG_W-1:0]  p_mag_next;
    quo_side_t                     p_side_next;

    always_comb
    begin
        p_side_next = n_side_reg;
        p_mag_next  = n_mag_reg;
        for (int l = 0; l < LANES; l++)
        begin
            if (OV_W'(n_mag_reg[l]) >= {n_dmag_reg, {QUO_W{1'b0}}})
            begin
                p_side_next.ov[l] = 1'b1;
                p_mag_next[l]     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_vld_reg <= 1'b0;
        else if (en)
            p_vld_reg <= n_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_mag_reg  <= p_mag_next;
            p_dmag_reg <= n_dmag_reg;
            p_side_reg <= p_side_next;
        end
    end

    // Output quotients.
    logic                         q_vld;
    logic [LANES-1:0][QUO_W-1:0]  q_quo;
    quo_side_t                    q_side;

    ccir_div #(
        .LANES  (LANES),
        .NUM_W  (NMAG_W),
        .DEN_W  (DEN_W),
        .Q_W    (QUO_W),
        .SIDE_W ($bits(quo_side_t))
    ) u_out_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_vld_reg),
        .in_num    (p_mag_reg),
        .in_den    (p_dmag_reg),
        .in_side   (p_side_reg),
        .out_valid (q_vld),
        .out_quo   (q_quo),
        .out_side  (q_side)
    );

    // Final stage: sign, saturation and flags into the output register.
    logic [TDATA_W-1:0] m_tdata_reg;
    logic [TUSER_W-1:0] m_tuser_reg;
    logic [TDATA_W-1:0] m_tdata_next;
    logic [TUSER_W-1:0] m_tuser_next;

    always_comb
    begin
        logic [VEL_W-1:0] val;
        logic             ovf;
        ovf          = 1'b0;
        m_tdata_next = '0;
        for (int l = 0; l < LANES; l++)
        begin
            if (q_side.dz)
            begin
                ovf = 1'b1;
                if (!q_side.nz[l])
                    val = '0;
                else
                    val = q_side.sneg[l] ? SAT_MIN : SAT_MAX;
            end
            else if (!q_side.sneg[l])
            begin
                if (q_side.ov[l] || q_quo[l][QUO_W-1])
                begin
                    val = SAT_MAX;
                    ovf = 1'b1;
                end
                else
                    val = q_quo[l];
            end
            else
            begin
                if (q_side.ov[l] || (q_quo[l][QUO_W-1] && (q_quo[l][QUO_W-2:0] != '0)))
                begin
                    val = SAT_MIN;
                    ovf = 1'b1;
                end
                else
                    val = -q_quo[l];
            end
            m_tdata_next[l*VEL_W +: VEL_W] = val;
        end
        if (q_side.err)
        begin
            m_tdata_next = '0;
            ovf          = 1'b0;
        end
        m_tuser_next = {ovf, q_side.err};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (en)
            m_tvalid_reg <= q_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- rtl/ccir_sqrt.sv -----
module ccir_sqrt #(
    parameter int RAD_W  = 64,
    parameter int SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [RAD_W-1:0]     in_rad,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [RAD_W/2-1:0]   out_root,
    output logic [SIDE_W-1:0]    out_side
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int TR_W   = RAD_W + 2;

    logic                vld_reg  [ROOT_W];
    logic [RAD_W-1:0]    rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]   root_reg [ROOT_W];
    logic [SIDE_W-1:0]   side_reg [ROOT_W];

    // One root bit per stage, most significant first.
    for (genvar s = 0; s < ROOT_W; s++) begin : g_step
        localparam int BIT = ROOT_W - 1 - s;

        logic              vld_in;
        logic [RAD_W-1:0]  rem_in;
        logic [RAD_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_in;
        logic [ROOT_W-1:0] root_next;
        logic [SIDE_W-1:0] side_in;
        logic [TR_W-1:0]   trial;

        if (s == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = in_rad;
            assign root_in = '0;
            assign side_in = in_side;
        end
        else begin : g_chain
            assign vld_in  = vld_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        // Try setting this bit: (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b).
        always_comb
        begin
            trial     = (TR_W'(root_in) << (BIT + 1)) + (TR_W'(1) << (2 * BIT));
            rem_next  = rem_in;
            root_next = root_in;
            if (TR_W'(rem_in) >= trial)
            begin
                rem_next       = rem_in - trial[RAD_W-1:0];
                root_next[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// ----- rtl/ccir_div.sv -----
module ccir_div #(
    parameter int LANES  = 1,
    parameter int NUM_W  = 8,
    parameter int DEN_W  = 8,
    parameter int Q_W    = 8,
    parameter int SIDE_W = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [LANES-1:0][NUM_W-1:0]   in_num,
    input  logic [DEN_W-1:0]              in_den,
    input  logic [SIDE_W-1:0]             in_side,
    output logic                          out_valid,
    output logic [LANES-1:0][Q_W-1:0]     out_quo,
    output logic [SIDE_W-1:0]             out_side
);

    // Every lane shares the divisor; each quotient must stay below 2^Q_W.
    localparam int CMP_W = DEN_W + Q_W;

    logic                          vld_reg  [Q_W];
    logic [LANES-1:0][NUM_W-1:0]   rem_reg  [Q_W];
    logic [LANES-1:0][Q_W-1:0]     quo_reg  [Q_W];
    logic [DEN_W-1:0]              den_reg  [Q_W];
    logic [SIDE_W-1:0]             side_reg [Q_W];

    // One quotient bit per stage, most significant first.
    for (genvar s = 0; s < Q_W; s++) begin : g_step
        localparam int BIT = Q_W - 1 - s;

        logic                        vld_in;
        logic [LANES-1:0][NUM_W-1:0] rem_in;
        logic [LANES-1:0][NUM_W-1:0] rem_next;
        logic [LANES-1:0][Q_W-1:0]   quo_in;
        logic [LANES-1:0][Q_W-1:0]   quo_next;
        logic [DEN_W-1:0]            den_in;
        logic [SIDE_W-1:0]           side_in;
        logic [CMP_W-1:0]            trial;

        if (s == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = in_num;
            assign quo_in  = '0;
            assign den_in  = in_den;
            assign side_in = in_side;
        end
        else begin : g_chain
            assign vld_in  = vld_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign quo_in  = quo_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        // Restoring step against the shifted divisor.
        always_comb
        begin
            trial    = CMP_W'(den_in) << BIT;
            rem_next = rem_in;
            quo_next = quo_in;
            for (int l = 0; l < LANES; l++)
            begin
                if (CMP_W'(rem_in[l]) >= trial)
                begin
                    rem_next[l]      = rem_in[l] - trial[NUM_W-1:0];
                    quo_next[l][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                quo_reg[s]  <= quo_next;
                den_reg[s]  <= den_in;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign out_quo   = quo_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

// ----- rtl/ccir_checker.sv -----
module ccir_checker
    import ccir_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [TDATA_W-1:0]    m_tdata,
    input logic [TUSER_W-1:0]    m_tuser
);

    // A result that is not taken stays on the output unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    // An error result carries zero rates and no overflow.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
        else $error("error result with nonzero payload");

    // The input is taken exactly when the output register can move.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output state");

    // No result is valid at the clock edge where reset is seen released.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result right after reset");

endmodule

bind collision_impulse_ode_rhs ccir_checker u_ccir_checker (.*);
